// ===== rtl/core/tlbpt_pkg.sv =====
// package for the page table translator: field widths, default sizes,
// sequencer states. no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlbpt_pkg;

  // fixed field widths
  localparam int VA_W  = 16;
  localparam int CNT_W = 32;

  // default sizes for the top-level parameters
  localparam int TLB_ENTRIES_DEF  = 16;
  localparam int PAGE_ENTRIES_DEF = 256;
  localparam int OFFSET_BITS_DEF  = 8;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD1,
    ST_MOD2,
    ST_READ,
    ST_EVAL
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/tlbpt_cmod.sv =====
// remainder of a narrow unsigned value by a constant divisor, two stages.
// reciprocal multiply, then back-multiply, then one subtract correction.
`timescale 1ns / 1ps
`default_nettype none

module tlbpt_cmod #(
  parameter int X_W     = 8,
  parameter int DIVISOR = 16,
  parameter int R_W     = 4
) (
  input  wire logic           clk,
  input  wire logic [X_W-1:0] x,
  output logic      [R_W-1:0] rem
);

  localparam int RECIP   = (2 ** X_W) / DIVISOR;
  localparam int RECIP_W = X_W + 1;
  localparam int DIV_W   = $clog2(DIVISOR + 1);
  localparam int P1_W    = X_W + RECIP_W;
  localparam int P2_W    = X_W + DIV_W;

  logic [X_W-1:0]  x1;
  logic [X_W-1:0]  q1;
  logic [X_W-1:0]  x2;
  logic [X_W-1:0]  p2;
  logic [P1_W-1:0] prod1;
  logic [P2_W-1:0] prod2;
  logic [P2_W-1:0] diff;
  logic [P2_W-1:0] fixed;

  // quotient estimate, exact or one short since x stays below 2**X_W
  assign prod1 = P1_W'(x) * P1_W'(RECIP);

  always_ff @(posedge clk) begin
    x1 <= x;
    q1 <= X_W'(prod1 >> X_W);
  end

  // back-multiply, never exceeds x
  assign prod2 = P2_W'(q1) * P2_W'(DIVISOR);

  always_ff @(posedge clk) begin
    x2 <= x1;
    p2 <= X_W'(prod2);
  end

  // single correction step, difference lies below twice the divisor
  always_comb begin
    diff  = P2_W'(x2) - P2_W'(p2);
    fixed = (diff >= P2_W'(DIVISOR)) ? diff - P2_W'(DIVISOR) : diff;
    rem   = R_W'(fixed);
  end

endmodule

`default_nettype wire

// ===== rtl/core/tlb_page_table_translator.sv =====
// direct-mapped tlb with demand-paging translation, top level.
// a word taken in idle passes states mod1, mod2, read and eval; its result is
// registered when eval fires, held off while the last result stalls. a new word
// is taken only back in idle. the two-stage remainder unit runs ahead of the
// synchronous tlb and page table reads. reset: a clearing pass sweeps the page
// table valid flags, holding req_ready low. depends on tlbpt_pkg, tlbpt_cmod.
`timescale 1ns / 1ps
`default_nettype none

module tlb_page_table_translator #(
  parameter int TLB_ENTRIES  = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int PAGE_ENTRIES = tlbpt_pkg::PAGE_ENTRIES_DEF,
  parameter int OFFSET_BITS  = tlbpt_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_ready,
  input  wire logic [tlbpt_pkg::VA_W-1:0]   virtual_address,
  output logic                              resp_valid,
  input  wire logic                         resp_ready,
  output logic      [tlbpt_pkg::VA_W-1:0]   physical_address,
  output logic                              tlb_hit,
  output logic                              page_fault,
  output logic      [tlbpt_pkg::CNT_W-1:0]  access_total,
  output logic      [tlbpt_pkg::CNT_W-1:0]  fault_total,
  output logic      [tlbpt_pkg::CNT_W-1:0]  hit_total
);

  localparam int VA_W    = tlbpt_pkg::VA_W;
  localparam int CNT_W   = tlbpt_pkg::CNT_W;
  localparam int PAGE_W  = (OFFSET_BITS < VA_W) ? VA_W - OFFSET_BITS : 1;
  localparam int SLOT_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int ROW_W   = $clog2(PAGE_ENTRIES);
  localparam int FRAME_W = $clog2(PAGE_ENTRIES + 1);

  typedef struct packed {
    logic [PAGE_W-1:0]  tag;
    logic [FRAME_W-1:0] frame;
  } tlb_entry_t;

  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame;
  } tbl_entry_t;

  tlbpt_pkg::state_t state, state_next;

  logic [VA_W-1:0]        va;
  logic [PAGE_W-1:0]      page;
  logic [OFFSET_BITS-1:0] offset;
  logic [SLOT_W-1:0]      slot_calc;
  logic [ROW_W-1:0]       row_calc;
  logic [SLOT_W-1:0]      slot_q;
  logic [ROW_W-1:0]       row_q;
  logic [ROW_W-1:0]       clr_idx;
  logic [TLB_ENTRIES-1:0] tlb_valid;
  logic [FRAME_W-1:0]     next_free;

  tlb_entry_t tlb_mem [TLB_ENTRIES];
  tbl_entry_t tbl_mem [PAGE_ENTRIES];
  tlb_entry_t tlb_rd;
  tbl_entry_t tbl_rd;

  logic               eval_fire;
  logic               hit;
  logic               fault;
  logic [FRAME_W-1:0] frame;
  logic [31:0]        pa_wide;
  logic               tbl_we;
  logic [ROW_W-1:0]   tbl_waddr;
  tbl_entry_t         tbl_wdata;

  // page and offset of the held word
  assign page   = PAGE_W'(va >> OFFSET_BITS);
  assign offset = va[OFFSET_BITS-1:0];

  // tlb slot and table row from the page number
  tlbpt_cmod #(
    .X_W     (PAGE_W),
    .DIVISOR (TLB_ENTRIES),
    .R_W     (SLOT_W)
  ) u_slot_mod (
    .clk (clk),
    .x   (page),
    .rem (slot_calc)
  );

  tlbpt_cmod #(
    .X_W     (PAGE_W),
    .DIVISOR (PAGE_ENTRIES),
    .R_W     (ROW_W)
  ) u_row_mod (
    .clk (clk),
    .x   (page),
    .rem (row_calc)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlbpt_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    eval_fire  = 1'b0;
    case (state)
      tlbpt_pkg::ST_CLEAR: begin
        if (clr_idx == ROW_W'(PAGE_ENTRIES - 1)) begin
          state_next = tlbpt_pkg::ST_IDLE;
        end
      end
      tlbpt_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = tlbpt_pkg::ST_MOD1;
        end
      end
      tlbpt_pkg::ST_MOD1: state_next = tlbpt_pkg::ST_MOD2;
      tlbpt_pkg::ST_MOD2: state_next = tlbpt_pkg::ST_READ;
      tlbpt_pkg::ST_READ: state_next = tlbpt_pkg::ST_EVAL;
      tlbpt_pkg::ST_EVAL: begin
        if (!resp_valid || resp_ready) begin
          eval_fire  = 1'b1;
          state_next = tlbpt_pkg::ST_IDLE;
        end
      end
      default: state_next = tlbpt_pkg::ST_IDLE;
    endcase
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      va <= virtual_address;
    end
  end

  // clearing sweep index
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == tlbpt_pkg::ST_CLEAR) begin
      clr_idx <= clr_idx + ROW_W'(1);
    end
  end

  // lookup: tag match, then page table, then fresh frame
  always_comb begin
    hit     = tlb_valid[slot_q] && (tlb_rd.tag == page);
    fault   = !hit && !tbl_rd.valid;
    frame   = hit ? tlb_rd.frame : (fault ? next_free : tbl_rd.frame);
    pa_wide = (32'(frame) << OFFSET_BITS) | 32'(offset);
  end

  // table write port: clearing sweep or new mapping
  always_comb begin
    if (state == tlbpt_pkg::ST_CLEAR) begin
      tbl_we    = 1'b1;
      tbl_waddr = clr_idx;
      tbl_wdata = '0;
    end else begin
      tbl_we          = eval_fire && fault;
      tbl_waddr       = row_q;
      tbl_wdata.valid = 1'b1;
      tbl_wdata.frame = next_free;
    end
  end

  // page table memory
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (state == tlbpt_pkg::ST_READ) begin
      tbl_rd <= tbl_mem[row_calc];
    end
  end

  // tlb tag and frame memory
  always_ff @(posedge clk) begin
    if (eval_fire && !hit) begin
      tlb_mem[slot_q] <= '{tag: page, frame: frame};
    end
    if (state == tlbpt_pkg::ST_READ) begin
      tlb_rd <= tlb_mem[slot_calc];
    end
  end

  // addresses kept for write-back
  always_ff @(posedge clk) begin
    if (state == tlbpt_pkg::ST_READ) begin
      slot_q <= slot_calc;
      row_q  <= row_calc;
    end
  end

  // tlb valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      tlb_valid <= '0;
    end else if (eval_fire && !hit) begin
      tlb_valid[slot_q] <= 1'b1;
    end
  end

  // frame allocator, saturating at the table size
  always_ff @(posedge clk) begin
    if (rst) begin
      next_free <= '0;
    end else if (eval_fire && fault && (next_free != FRAME_W'(PAGE_ENTRIES))) begin
      next_free <= next_free + FRAME_W'(1);
    end
  end

  // running counters, shown directly as result fields
  always_ff @(posedge clk) begin
    if (rst) begin
      access_total <= '0;
      fault_total  <= '0;
      hit_total    <= '0;
    end else if (eval_fire) begin
      access_total <= access_total + CNT_W'(1);
      fault_total  <= fault_total + CNT_W'(fault);
      hit_total    <= hit_total + CNT_W'(hit);
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (eval_fire) begin
      resp_valid <= 1'b1;
    end else if (resp_ready) begin
      resp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_fire) begin
      physical_address <= pa_wide[VA_W-1:0];
      tlb_hit          <= hit;
      page_fault       <= fault;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tlbpt_checker.sv =====
// port-level checks for the page table translator, bound to the top level.
// depends on tlbpt_pkg and tlb_page_table_translator.
`timescale 1ns / 1ps
`default_nettype none

module tlbpt_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        resp_valid,
  input wire logic                        resp_ready,
  input wire logic [tlbpt_pkg::VA_W-1:0]  physical_address,
  input wire logic                        tlb_hit,
  input wire logic                        page_fault,
  input wire logic [tlbpt_pkg::CNT_W-1:0] access_total,
  input wire logic [tlbpt_pkg::CNT_W-1:0] fault_total,
  input wire logic [tlbpt_pkg::CNT_W-1:0] hit_total
);

  localparam int CNT_W = tlbpt_pkg::CNT_W;

  logic             resp_fire;
  logic [CNT_W-1:0] prev_access;
  logic [CNT_W-1:0] prev_fault;
  logic [CNT_W-1:0] prev_hit;

  assign resp_fire = resp_valid && resp_ready;

  // totals seen on the last delivered word
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_access <= '0;
      prev_fault  <= '0;
      prev_hit    <= '0;
    end else if (resp_fire) begin
      prev_access <= access_total;
      prev_fault  <= fault_total;
      prev_hit    <= hit_total;
    end
  end

  // a stalled result word holds
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid && $stable(physical_address)
      && $stable(tlb_hit) && $stable(page_fault))
    else $error("result word changed while stalled");

  // a tlb hit never allocates a frame
  a_hit_no_fault: assert property (@(posedge clk) disable iff (rst)
    resp_valid |-> !(tlb_hit && page_fault))
    else $error("hit and fault flagged together");

  // each delivered word moves the totals by its own flags
  a_totals_step: assert property (@(posedge clk) disable iff (rst)
    resp_fire |-> (access_total == prev_access + CNT_W'(1))
      && (fault_total == prev_fault + CNT_W'(page_fault))
      && (hit_total == prev_hit + CNT_W'(tlb_hit)))
    else $error("running totals out of step with flags");

  // no word is offered straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !resp_valid)
    else $error("result offered after reset");

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (.*);

`default_nettype wire

// ===== test/tb_tlb_page_table_translator.sv =====
// self-checking testbench for tlb_page_table_translator: directed words, then random
// address streams under three idling patterns, results checked against hand-worked values or a predictor.
// depends on tlbpt_pkg and the translator rtl.
`timescale 1ns / 1ps

module tb_tlb_page_table_translator;

  localparam int TLB_SLOTS  = tlbpt_pkg::TLB_ENTRIES_DEF;
  localparam int PT_ROWS    = tlbpt_pkg::PAGE_ENTRIES_DEF;
  localparam int OFF_W      = tlbpt_pkg::OFFSET_BITS_DEF;
  localparam int VA_W       = tlbpt_pkg::VA_W;
  localparam int CNT_W      = tlbpt_pkg::CNT_W;
  localparam int NUM_PAGES  = 1 << (VA_W - OFF_W);
  localparam int HALF_CLK   = 6;
  localparam int STALL_MAX  = 3000;
  localparam int TAIL_WAIT  = 12;
  localparam int PHASE_LEN  = 200;
  localparam int HOT_PAGES  = 8;
  localparam int N_DIRECTED = 14;

  // one translation result
  typedef struct packed {
    logic [VA_W-1:0]  phys;
    logic             hit;
    logic             fault;
    logic [CNT_W-1:0] accesses;
    logic [CNT_W-1:0] faults;
    logic [CNT_W-1:0] hits;
  } xlat_t;

  // directed stimulus row, with a hand-worked result where one is given
  typedef struct packed {
    logic            worked;
    logic [VA_W-1:0] va;
    xlat_t           result;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  logic [VA_W-1:0]  virtual_address = '0;
  logic             resp_valid;
  logic             resp_ready = 1'b0;
  logic [VA_W-1:0]  physical_address;
  logic             tlb_hit;
  logic             page_fault;
  logic [CNT_W-1:0] access_total;
  logic [CNT_W-1:0] fault_total;
  logic [CNT_W-1:0] hit_total;

  tlb_page_table_translator u_dut (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_ready        (req_ready),
    .virtual_address  (virtual_address),
    .resp_valid       (resp_valid),
    .resp_ready       (resp_ready),
    .physical_address (physical_address),
    .tlb_hit          (tlb_hit),
    .page_fault       (page_fault),
    .access_total     (access_total),
    .fault_total      (fault_total),
    .hit_total        (hit_total)
  );

  always #HALF_CLK clk = ~clk;

  // predictor state: tlb, page table, frame allocator, counters
  bit               slot_valid [TLB_SLOTS];
  int unsigned      slot_tag   [TLB_SLOTS];
  int unsigned      slot_frame [TLB_SLOTS];
  bit               row_mapped [PT_ROWS];
  int unsigned      row_frame  [PT_ROWS];
  int unsigned      frames_used;
  logic [CNT_W-1:0] access_count;
  logic [CNT_W-1:0] fault_count;
  logic [CNT_W-1:0] hit_count;

  xlat_t            pending_xlats[$];
  int               error_count = 0;
  int               quiet_cycles = 0;
  int               send_idle_pct = 0;
  int               resp_stall_pct = 0;
  bit               word_worked = 1'b0;
  xlat_t            word_result = '0;
  int unsigned      hot_pages [HOT_PAGES];
  dir_row_t         directed_rows [N_DIRECTED];

  // translate one address and advance the predictor state
  function automatic xlat_t translate_address(input logic [VA_W-1:0] va);
    int unsigned page;
    int unsigned offset;
    int unsigned slot;
    int unsigned row;
    int unsigned frame;
    xlat_t       r;
    page   = int'(va) >> OFF_W;
    offset = int'(va) & ((1 << OFF_W) - 1);
    slot   = page % TLB_SLOTS;
    row    = page % PT_ROWS;
    r      = '0;
    access_count = access_count + 1'b1;
    if (slot_valid[slot] && slot_tag[slot] == page) begin
      frame     = slot_frame[slot];
      r.hit     = 1'b1;
      hit_count = hit_count + 1'b1;
    end else begin
      // demand paging: allocate frames in order, saturating at the table size
      if (!row_mapped[row]) begin
        row_mapped[row] = 1'b1;
        row_frame[row]  = frames_used;
        if (frames_used < PT_ROWS) frames_used++;
        r.fault     = 1'b1;
        fault_count = fault_count + 1'b1;
      end
      frame            = row_frame[row];
      slot_valid[slot] = 1'b1;
      slot_tag[slot]   = page;
      slot_frame[slot] = frame;
    end
    r.phys     = VA_W'(((frame << OFF_W) | offset) & ((1 << VA_W) - 1));
    r.accesses = access_count;
    r.faults   = fault_count;
    r.hits     = hit_count;
    return r;
  endfunction

  // random address: mostly a hot working set and tlb conflicts, some fresh pages
  function automatic logic [VA_W-1:0] pick_address();
    int unsigned page;
    int unsigned pick;
    int unsigned start;
    pick = $urandom_range(99);
    if (pick < 45) begin
      page = hot_pages[$urandom_range(HOT_PAGES - 1)];
    end else if (pick < 65) begin
      // same tlb slot as a hot page, different tag
      page = (hot_pages[$urandom_range(HOT_PAGES - 1)]
              + TLB_SLOTS * $urandom_range(1, NUM_PAGES / TLB_SLOTS - 1)) % NUM_PAGES;
    end else if (pick < 85) begin
      // a page that has not been mapped yet, if any is left
      start = $urandom_range(NUM_PAGES - 1);
      page  = start;
      for (int i = 0; i < NUM_PAGES; i++) begin
        if (!row_mapped[(start + i) % NUM_PAGES % PT_ROWS]) begin
          page = (start + i) % NUM_PAGES;
          break;
        end
      end
    end else begin
      page = $urandom_range(NUM_PAGES - 1);
    end
    hot_pages[$urandom_range(HOT_PAGES - 1)] = page;
    return VA_W'((page << OFF_W) | $urandom_range((1 << OFF_W) - 1));
  endfunction

  // present one word, idling beforehand at the sender's rate; entered and left at a falling edge
  task automatic send_word(input logic [VA_W-1:0] va, input bit worked, input xlat_t result);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid       <= 1'b1;
    virtual_address <= va;
    word_worked     = worked;
    word_result     = result;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  // hold the sender until every expected result is back
  task automatic drain_results();
    req_valid <= 1'b0;
    while (pending_xlats.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    resp_ready <= ($urandom_range(99) >= resp_stall_pct);
  end

  // accept words into the predictor and check results as they leave
  always @(posedge clk) begin
    xlat_t predicted;
    xlat_t want;
    if (!rst) begin
      if (req_valid && req_ready) begin
        predicted = translate_address(virtual_address);
        pending_xlats.push_back(word_worked ? word_result : predicted);
      end
      if (resp_valid && resp_ready) begin
        if (pending_xlats.size() == 0) begin
          $error("result with nothing expected: physical_address %h", physical_address);
          error_count++;
        end else begin
          want = pending_xlats.pop_front();
          if (physical_address !== want.phys) begin
            $error("physical_address: expected %h, got %h", want.phys, physical_address);
            error_count++;
          end
          if (tlb_hit !== want.hit) begin
            $error("tlb_hit: expected %b, got %b", want.hit, tlb_hit);
            error_count++;
          end
          if (page_fault !== want.fault) begin
            $error("page_fault: expected %b, got %b", want.fault, page_fault);
            error_count++;
          end
          if (access_total !== want.accesses) begin
            $error("access_total: expected %0d, got %0d", want.accesses, access_total);
            error_count++;
          end
          if (fault_total !== want.faults) begin
            $error("fault_total: expected %0d, got %0d", want.faults, fault_total);
            error_count++;
          end
          if (hit_total !== want.hits) begin
            $error("hit_total: expected %0d, got %0d", want.hits, hit_total);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (resp_valid && resp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("[tlb_page_table_translator] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // predictor reset
    for (int i = 0; i < TLB_SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_tag[i]   = 0;
      slot_frame[i] = 0;
    end
    for (int i = 0; i < PT_ROWS; i++) begin
      row_mapped[i] = 1'b0;
      row_frame[i]  = 0;
    end
    frames_used  = 0;
    access_count = '0;
    fault_count  = '0;
    hit_count    = '0;
    for (int i = 0; i < HOT_PAGES; i++) hot_pages[i] = i * 37 % NUM_PAGES;

    // extremes, tlb conflict misses with and without a fault, repeat hits
    directed_rows = '{
      '{1'b1, 16'h0000, '{16'h0000, 1'b0, 1'b1, 32'd1, 32'd1, 32'd0}},
      '{1'b1, 16'h00FF, '{16'h00FF, 1'b1, 1'b0, 32'd2, 32'd1, 32'd1}},
      '{1'b1, 16'hFFFF, '{16'h01FF, 1'b0, 1'b1, 32'd3, 32'd2, 32'd1}},
      '{1'b1, 16'hFF00, '{16'h0100, 1'b1, 1'b0, 32'd4, 32'd2, 32'd2}},
      '{1'b1, 16'h1000, '{16'h0200, 1'b0, 1'b1, 32'd5, 32'd3, 32'd2}},
      '{1'b1, 16'h0034, '{16'h0034, 1'b0, 1'b0, 32'd6, 32'd3, 32'd2}},
      '{1'b1, 16'h0034, '{16'h0034, 1'b1, 1'b0, 32'd7, 32'd3, 32'd3}},
      '{1'b1, 16'h1080, '{16'h0280, 1'b0, 1'b0, 32'd8, 32'd3, 32'd3}},
      '{1'b0, 16'hAAAA, xlat_t'('0)},
      '{1'b0, 16'h5555, xlat_t'('0)},
      '{1'b0, 16'hAA55, xlat_t'('0)},
      '{1'b0, 16'h8001, xlat_t'('0)},
      '{1'b0, 16'h7FFE, xlat_t'('0)},
      '{1'b0, 16'h0F0F, xlat_t'('0)}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed words, no idling
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_word(directed_rows[i].va, directed_rows[i].worked, directed_rows[i].result);
    end
    drain_results();

    // random phases: receiver mostly stalls, then sender mostly idles, then neither
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 36 : (ph == 1) ? 78 : 0;
      resp_stall_pct = (ph == 0) ? 78 : (ph == 1) ? 36 : 0;
      for (int n = 0; n < PHASE_LEN; n++) begin
        send_word(pick_address(), 1'b0, xlat_t'('0));
      end
      drain_results();
    end

    // final drain and tail
    while (pending_xlats.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("[tlb_page_table_translator] OK");
    end else begin
      $display("[tlb_page_table_translator] ERROR");
    end
    $finish;
  end

endmodule
